@@ src/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash command controller package
// Field widths, operation and command codes, state types and shared helpers.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int OP_W            = 2;
   localparam int KEY_W           = 8;
   localparam int CMD_W           = 4;
   localparam int ARG_W           = 16;
   localparam int DATA_W          = 32;
   localparam int REGIONS_W       = 8;
   localparam int LOCK_WORD_COUNT = 4;
   localparam int LOCK_ADDR_W     = 2;
   localparam int BIT_IDX_W       = 5;

   localparam logic [REGIONS_W-1:0] REGIONS_RESET = 8'd128;
   localparam logic [KEY_W-1:0]     WRITE_KEY     = 8'h5A;

   localparam logic [OP_W-1:0] OP_STATUS  = 2'd0;
   localparam logic [OP_W-1:0] OP_RESULT  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMMAND = 2'd2;

   localparam logic [CMD_W-1:0] CMD_WRITE_PAGE       = 4'h1;
   localparam logic [CMD_W-1:0] CMD_WRITE_LOCK       = 4'h2;
   localparam logic [CMD_W-1:0] CMD_ERASE_WRITE      = 4'h3;
   localparam logic [CMD_W-1:0] CMD_ERASE_WRITE_LOCK = 4'h4;
   localparam logic [CMD_W-1:0] CMD_ERASE_ALL        = 4'h5;
   localparam logic [CMD_W-1:0] CMD_ERASE_PAGES      = 4'h7;
   localparam logic [CMD_W-1:0] CMD_SET_LOCK         = 4'h8;
   localparam logic [CMD_W-1:0] CMD_CLEAR_LOCK       = 4'h9;
   localparam logic [CMD_W-1:0] CMD_GET_LOCK         = 4'hA;
   localparam logic [CMD_W-1:0] CMD_SET_GP           = 4'hB;
   localparam logic [CMD_W-1:0] CMD_CLEAR_GP         = 4'hC;
   localparam logic [CMD_W-1:0] CMD_GET_GP           = 4'hD;

   localparam logic [1:0] ERR_NONE = 2'b00;
   localparam logic [1:0] ERR_CMD  = 2'b01;
   localparam logic [1:0] ERR_LOCK = 2'b10;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LOCK = 2'd1;
   localparam logic [1:0] KIND_GP   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_SCAN,
      ST_EXEC,
      ST_DONE
   } fcc_state_type;

   typedef struct packed {
      logic                   in_range;
      logic [LOCK_ADDR_W-1:0] word;
      logic [BIT_IDX_W-1:0]   bit_idx;
      logic [REGIONS_W-1:0]   active;
   } fcc_loc_type;

   typedef struct packed {
      logic                   we;
      logic [LOCK_ADDR_W-1:0] waddr;
      logic [DATA_W-1:0]      wdata;
      logic                   re;
      logic [LOCK_ADDR_W-1:0] raddr;
   } fcc_ram_ctl_type;

   function automatic logic [DATA_W-1:0] fcc_status(input logic [1:0] err);
      fcc_status = {{(DATA_W-3){1'b0}}, err, 1'b1};
   endfunction

endpackage

@@ src/fcc_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one bus access to the controller.
// ----------------------------------------------------------------------------
interface fcc_req_if;
   logic                       valid;
   logic                       ready;
   logic [fcc_pkg::OP_W-1:0]   operation;
   logic [fcc_pkg::KEY_W-1:0]  key;
   logic [fcc_pkg::CMD_W-1:0]  command;
   logic [fcc_pkg::ARG_W-1:0]  argument;

   modport source (output valid, operation, key, command, argument, input ready);
   modport sink   (input valid, operation, key, command, argument, output ready);
endinterface

@@ src/fcc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that returns the read data of one bus access.
// ----------------------------------------------------------------------------
interface fcc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fcc_pkg::DATA_W-1:0] read_data;
   logic                       accepted;

   modport source (output valid, read_data, accepted, input ready);
   modport sink   (input valid, read_data, accepted, output ready);
endinterface

@@ src/fcc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module fcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/fcc_addr.sv @@
// ----------------------------------------------------------------------------
// Region locator
// Turns a page number into a lock region by a registered reciprocal multiply
// and checks it against the number of regions in effect.
// ----------------------------------------------------------------------------
module fcc_addr #(
   parameter int LOCK_REGIONS     = 128,
   parameter int PAGES_PER_REGION = 32
) (
   input  logic                             clock,
   input  logic                             load,
   input  logic [fcc_pkg::ARG_W-1:0]        argument,
   input  logic [fcc_pkg::REGIONS_W-1:0]    regions,
   output fcc_pkg::fcc_loc_type             loc
);
   import fcc_pkg::*;

   localparam int PAGE_SHIFT = $clog2(PAGES_PER_REGION);
   localparam int SH         = ARG_W + PAGE_SHIFT;
   localparam int RECIP_W    = ARG_W + 1;
   localparam int PROD_W     = ARG_W + RECIP_W;
   localparam int REGION_W   = PROD_W - SH;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SH) / PAGES_PER_REGION + 1);

   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W-1:0]    prod_in;
   logic [REGION_W-1:0]  region;
   logic [REGIONS_W-1:0] active;

   assign prod_in = PROD_W'(argument) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign region = prod_ff[PROD_W-1:SH];
   assign active = (regions < REGIONS_W'(LOCK_REGIONS)) ? regions : REGIONS_W'(LOCK_REGIONS);

   assign loc.in_range = region < REGION_W'(active);
   assign loc.word     = region[BIT_IDX_W+LOCK_ADDR_W-1:BIT_IDX_W];
   assign loc.bit_idx  = region[BIT_IDX_W-1:0];
   assign loc.active   = active;

endmodule

@@ src/fcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Command sequencer
// Reads the lock word memory, executes one access, writes the word back when a
// command sets or clears a lock bit, and holds the response in an output register.
// ----------------------------------------------------------------------------
module fcc_ctrl #(
   parameter int GP_BIT_COUNT = 9
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fcc_req_if.sink                              req,
   fcc_rsp_if.source                            rsp,
   input  fcc_pkg::fcc_loc_type                 loc,
   output fcc_pkg::fcc_ram_ctl_type             ram_ctl,
   input  logic [fcc_pkg::DATA_W-1:0]           ram_rdata
);
   import fcc_pkg::*;

   localparam int GP_IDX_W = (GP_BIT_COUNT > 1) ? $clog2(GP_BIT_COUNT) : 1;

   fcc_state_type state_ff, state_in;

   logic [OP_W-1:0]            op_ff;
   logic [KEY_W-1:0]           key_ff;
   logic [CMD_W-1:0]           cmd_ff;
   logic [ARG_W-1:0]           arg_ff;
   logic [1:0]                 err_ff, err_in;
   logic [GP_BIT_COUNT-1:0]    gp_ff, gp_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [LOCK_ADDR_W-1:0]     idx_ff, idx_in;
   logic [LOCK_WORD_COUNT-1:0] valid_ff;
   logic                       rd_valid_ff, rd_valid_in;
   logic [LOCK_ADDR_W-1:0]     scan_ff, scan_in;
   logic                       acc_ff, acc_in;
   logic [DATA_W-1:0]          res_data_ff, res_data_in;
   logic                       res_ok_ff, res_ok_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]          rsp_data_ff;
   logic                       rsp_ok_ff;

   logic                       accept;
   logic                       rsp_load;
   logic                       scan_cmd;
   logic [DATA_W-1:0]          word_rd;
   logic [DATA_W-1:0]          scan_mask;
   logic [DATA_W-1:0]          bit_mask;
   logic                       wr_en;
   logic [DATA_W-1:0]          wr_data;
   logic [GP_IDX_W-1:0]        gp_idx;
   logic [GP_BIT_COUNT-1:0]    gp_mask;

   assign accept   = req.valid && req.ready;
   assign scan_cmd = (op_ff == OP_COMMAND) && (key_ff == WRITE_KEY) && (cmd_ff == CMD_ERASE_ALL);
   assign word_rd  = rd_valid_ff ? ram_rdata : '0;
   assign bit_mask = DATA_W'(1) << loc.bit_idx;
   assign gp_idx   = arg_ff[GP_IDX_W-1:0];
   assign gp_mask  = GP_BIT_COUNT'(1) << gp_idx;

   always_comb begin
      for (int b = 0; b < DATA_W; b++) begin
         scan_mask[b] = REGIONS_W'({scan_ff, BIT_IDX_W'(b)}) < loc.active;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = scan_cmd ? ST_SCAN : ST_EXEC;
         end
         ST_SCAN: begin
            if (scan_ff == LOCK_ADDR_W'(LOCK_WORD_COUNT - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req.ready     = 1'b0;
      ram_ctl.re    = 1'b0;
      ram_ctl.raddr = loc.word;
      ram_ctl.we    = 1'b0;
      ram_ctl.waddr = loc.word;
      ram_ctl.wdata = wr_data;
      rsp_load      = 1'b0;
      scan_in       = scan_ff;
      acc_in        = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_ADDR: begin
            ram_ctl.re = 1'b1;
            scan_in    = '0;
            acc_in     = 1'b0;
            if (op_ff == OP_RESULT) begin
               ram_ctl.raddr = idx_ff;
            end else if (scan_cmd) begin
               ram_ctl.raddr = '0;
            end
         end
         ST_SCAN: begin
            ram_ctl.re    = 1'b1;
            ram_ctl.raddr = scan_ff + 1'b1;
            scan_in       = scan_ff + 1'b1;
            acc_in        = acc_ff | (|(word_rd & scan_mask));
         end
         ST_EXEC: begin
            ram_ctl.we = wr_en;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
         end
      endcase
   end

   assign rd_valid_in = valid_ff[ram_ctl.raddr];

   // Execution of one access on the word read from memory.
   always_comb begin
      logic [1:0] err_new;
      err_new     = ERR_NONE;
      err_in      = err_ff;
      gp_in       = gp_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      res_data_in = '0;
      res_ok_in   = 1'b0;
      wr_en       = 1'b0;
      wr_data     = word_rd;
      case (op_ff)
         OP_STATUS: begin
            res_data_in = fcc_status(err_ff);
         end
         OP_RESULT: begin
            case (kind_ff)
               KIND_LOCK: begin
                  res_data_in = word_rd;
                  idx_in      = idx_ff + 1'b1;
               end
               KIND_GP: begin
                  res_data_in = DATA_W'(gp_ff);
               end
               default: begin
               end
            endcase
         end
         OP_COMMAND: begin
            kind_in = KIND_NONE;
            idx_in  = '0;
            if (key_ff != WRITE_KEY) begin
               err_new = ERR_CMD;
            end else begin
               case (cmd_ff)
                  CMD_WRITE_PAGE, CMD_WRITE_LOCK, CMD_ERASE_WRITE,
                  CMD_ERASE_WRITE_LOCK, CMD_ERASE_PAGES: begin
                     if (!loc.in_range) begin
                        err_new = ERR_CMD;
                     end else if (|(word_rd & bit_mask)) begin
                        err_new = ERR_LOCK;
                     end else if (cmd_ff inside {CMD_WRITE_LOCK, CMD_ERASE_WRITE_LOCK}) begin
                        wr_en   = 1'b1;
                        wr_data = word_rd | bit_mask;
                     end
                  end
                  CMD_ERASE_ALL: begin
                     if (acc_ff) begin
                        err_new = ERR_LOCK;
                     end
                  end
                  CMD_SET_LOCK, CMD_CLEAR_LOCK: begin
                     if (!loc.in_range) begin
                        err_new = ERR_CMD;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = (cmd_ff == CMD_SET_LOCK) ? (word_rd | bit_mask)
                                                           : (word_rd & ~bit_mask);
                     end
                  end
                  CMD_GET_LOCK: begin
                     kind_in = KIND_LOCK;
                  end
                  CMD_SET_GP, CMD_CLEAR_GP: begin
                     if (arg_ff >= ARG_W'(GP_BIT_COUNT)) begin
                        err_new = ERR_CMD;
                     end else if (cmd_ff == CMD_SET_GP) begin
                        gp_in = gp_ff | gp_mask;
                     end else begin
                        gp_in = gp_ff & ~gp_mask;
                     end
                  end
                  CMD_GET_GP: begin
                     kind_in = KIND_GP;
                  end
                  default: begin
                     err_new = ERR_CMD;
                  end
               endcase
            end
            err_in      = err_new;
            res_ok_in   = (err_new == ERR_NONE);
            res_data_in = fcc_status(err_new);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_ff       <= ERR_NONE;
         gp_ff        <= '0;
         kind_ff      <= KIND_NONE;
         idx_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_EXEC) begin
            err_ff  <= err_in;
            gp_ff   <= gp_in;
            kind_ff <= kind_in;
            idx_ff  <= idx_in;
         end
         if (ram_ctl.we) begin
            valid_ff[ram_ctl.waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req.operation;
         key_ff <= req.key;
         cmd_ff <= req.command;
         arg_ff <= req.argument;
      end
      rd_valid_ff <= rd_valid_in;
      scan_ff     <= scan_in;
      acc_ff      <= acc_in;
      if (state_ff == ST_EXEC) begin
         res_data_ff <= res_data_in;
         res_ok_ff   <= res_ok_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_data_ff;
         rsp_ok_ff   <= res_ok_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
   assign rsp.accepted  = rsp_ok_ff;

endmodule

@@ src/flash_command_controller.sv @@
// ----------------------------------------------------------------------------
// Flash command controller
// Register level command interface of an embedded flash controller: command
// key check, region lock bits held in a small memory, general purpose bits,
// error flags and result reads.
// ----------------------------------------------------------------------------
// A transfer passes through the address, execute and done states; erase all
// adds a scan state. No new transfer is taken until the sequencer is idle again,
// after the read, modify and write of the lock word memory.
// Erase all reads the four lock words one per cycle.
// Reset is synchronous; lock words, gp bits and errors read as zero after it.
module flash_command_controller #(
   parameter int LOCK_REGIONS     = 128,
   parameter int GP_BIT_COUNT     = 9,
   parameter int PAGES_PER_REGION = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   fcc_req_if.sink                          req_chan,
   fcc_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [fcc_pkg::REGIONS_W-1:0]    csr_write_data
);
   import fcc_pkg::*;

   logic [REGIONS_W-1:0] csr_regions_ff;
   fcc_loc_type          loc;
   fcc_ram_ctl_type      ram_ctl;
   logic [DATA_W-1:0]    ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_regions_ff <= REGIONS_RESET;
      end else if (csr_write_enable) begin
         csr_regions_ff <= csr_write_data;
      end
   end

   fcc_addr #(
      .LOCK_REGIONS     (LOCK_REGIONS),
      .PAGES_PER_REGION (PAGES_PER_REGION)
   ) u_addr (
      .clock    (clock),
      .load     (req_chan.valid && req_chan.ready),
      .argument (req_chan.argument),
      .regions  (csr_regions_ff),
      .loc      (loc)
   );

   fcc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LOCK_WORD_COUNT)
   ) u_lock_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   fcc_ctrl #(
      .GP_BIT_COUNT (GP_BIT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .loc       (loc),
      .ram_ctl   (ram_ctl),
      .ram_rdata (ram_rdata)
   );

endmodule

@@ src/fcc_checker.sv @@
// ----------------------------------------------------------------------------
// Flash command controller checker
// Port level properties of the controller, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fcc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fcc_pkg::DATA_W-1:0] rsp_read_data,
   input logic                       rsp_accepted
);
   import fcc_pkg::*;

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One transfer is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // An accepted command always reports a clean status word.
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_read_data == fcc_status(ERR_NONE)))
      else $error("accepted command with error status");

   // A stalled response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("stalled response changed");

endmodule

bind flash_command_controller fcc_checker u_fcc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_accepted  (rsp_chan.accepted)
);
